// ----- hw/rtl/fvnh_pkg.sv -----
package fvnh_pkg;

	localparam int MAX_OCTAVES_DEF = 16;
	localparam int FADE_DEPTH_DEF  = 256;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int OCT_W = 5;
	localparam int FADE_W = 17;
	localparam int LAT_W = 18;
	localparam int SMOOTH_W = 20;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam longint PiQ30 = 64'sd3373259426;
	localparam longint Q30One = 64'sd1073741824;
	localparam longint SeriesDiv [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

	localparam logic [OCT_W-1:0] OCT_RST = 5'd4;
	localparam logic signed [31:0] AMP_RST = 32'sd65536;
	localparam logic signed [31:0] FREQ_RST = 32'sd65536;
	localparam logic signed [31:0] GAIN_RST = 32'sd32768;
	localparam logic signed [31:0] OFFSET_RST = 32'sd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OCTAVES = 3'd0,
		CFG_AMPLITUDE = 3'd1,
		CFG_FREQUENCY = 3'd2,
		CFG_GAIN = 3'd3,
		CFG_OFFSET = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic sat;
	} qmul_t;

	typedef struct packed {
		logic sat;
		logic signed [31:0] nz;
		logic signed [31:0] amp;
		logic signed [31:0] ret;
	} rnd_t;

	typedef struct packed {
		logic sat;
		logic [FADE_W-1:0] fx;
		logic [FADE_W-1:0] fy;
	} ctl_t;

	function automatic qmul_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [47:0] s;
		qmul_t r;
		p = 64'(a) * 64'(b);
		s = p[63:16];
		r.sat = !((s[47:31] == '0) || (s[47:31] == '1));
		if (r.sat) begin
			r.v = s[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r.v = s[31:0];
		end
		return r;
	endfunction

	// sin^2 of a Q30 angle by a 13th-order series, rounded to unsigned Q1.16
	function automatic logic [FADE_W-1:0] fade_q16(input longint u);
		longint term;
		longint sum;
		longint s2;
		term = u;
		sum = u;
		for (int k = 1; k <= 6; k++) begin
			term = (term * u) >>> 30;
			term = ((term * u) >>> 30) / SeriesDiv[k-1];
			if ((k & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > Q30One) begin
			sum = Q30One;
		end
		s2 = (sum * sum) >>> 30;
		return FADE_W'((s2 + 64'sd8192) >>> 14);
	endfunction

endpackage

// ----- hw/rtl/fractal_value_noise_height_top.sv -----
// Fractal value-noise height generator.
// Input: pulse start with coord_x/coord_y (signed Q16.16); a sample is
// transferred at every clock edge where start is high and busy is low.
// busy stays low, so a new sample can be taken in every cycle.
// Output: done is high for one cycle with height and saturated; the
// receiver must take the result in that cycle, it cannot hold it off.
// Pipeline: the result is transferred after nine stages of scaling, lattice
// hashing, smoothing and cosine blend, three stages per octave round and
// one output register. Rounds beyond the octave setting pass through.
// Throughput: one sample per cycle.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write a register at the clock
// edge; write only while no sample is in flight. Addresses above four are
// dropped.
// Reset: arst_n clears the pipeline valid bits and loads register defaults;
// no clearing pass is needed, samples are taken from the first cycle on.
module fractal_value_noise_height_top #(
	parameter int MAX_OCTAVES = fvnh_pkg::MAX_OCTAVES_DEF,
	parameter int FADE_TABLE_DEPTH = fvnh_pkg::FADE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [31:0]                  coord_x,
	input  logic signed [31:0]                  coord_y,
	output logic                                done,
	output logic signed [31:0]                  height,
	output logic                                saturated,
	input  logic                                cfg_wr_en,
	input  logic [fvnh_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [fvnh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(FADE_TABLE_DEPTH);
	localparam int NR = MAX_OCTAVES - 1;
	localparam int SMW = fvnh_pkg::SMOOTH_W;
	localparam int FW = fvnh_pkg::FADE_W;

	logic [fvnh_pkg::OCT_W-1:0] octave_count_q;
	logic signed [31:0] start_amplitude_q;
	logic signed [31:0] frequency_q;
	logic signed [31:0] gain_h_q;
	logic signed [31:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= fvnh_pkg::OCT_RST;
			start_amplitude_q <= fvnh_pkg::AMP_RST;
			frequency_q <= fvnh_pkg::FREQ_RST;
			gain_h_q <= fvnh_pkg::GAIN_RST;
			offset_q <= fvnh_pkg::OFFSET_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				fvnh_pkg::CFG_OCTAVES: octave_count_q <= cfg_wdata[fvnh_pkg::OCT_W-1:0];
				fvnh_pkg::CFG_AMPLITUDE: start_amplitude_q <= cfg_wdata;
				fvnh_pkg::CFG_FREQUENCY: frequency_q <= cfg_wdata;
				fvnh_pkg::CFG_GAIN: gain_h_q <= cfg_wdata;
				fvnh_pkg::CFG_OFFSET: offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	function automatic logic signed [SMW-1:0] blend(
		input logic signed [SMW-1:0] a,
		input logic signed [SMW-1:0] b,
		input logic [FW-1:0] f
	);
		logic signed [SMW:0] d;
		logic signed [SMW+18:0] p;
		d = {b[SMW-1], b} - {a[SMW-1], a};
		p = (SMW+19)'(d) * (SMW+19)'(signed'({1'b0, f}));
		return a + SMW'(p >>> 16);
	endfunction

	logic [FW-1:0] fade_rom [FADE_TABLE_DEPTH];

	for (genvar g = 0; g < FADE_TABLE_DEPTH; g++) begin : g_fade
		localparam longint U = (longint'(g) * fvnh_pkg::PiQ30) / (2 * FADE_TABLE_DEPTH);
		localparam logic [FW-1:0] FV = fvnh_pkg::fade_q16(U);
		assign fade_rom[g] = FV;
	end

	logic accept;
	fvnh_pkg::qmul_t qx;
	fvnh_pkg::qmul_t qy;

	assign busy = 1'b0;
	assign accept = start & ~busy;
	assign qx = fvnh_pkg::qmul(coord_x, frequency_q);
	assign qy = fvnh_pkg::qmul(coord_y, frequency_q);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic signed [31:0] sx_s1;
	logic signed [31:0] sy_s1;
	logic sat_s1;
	logic sat_s2;
	logic [31:0] ix_s2;
	logic [31:0] iy_s2;
	logic [IDX_W-1:0] idxx_s2;
	logic [IDX_W-1:0] idxy_s2;
	fvnh_pkg::ctl_t ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic signed [SMW-1:0] sm_s7 [4];
	logic signed [SMW-1:0] bx0_s8;
	logic signed [SMW-1:0] bx1_s8;
	fvnh_pkg::rnd_t rnd_s9;

	logic [31:0] ix_c;
	logic [31:0] iy_c;
	logic [IDX_W-1:0] idxx_c;
	logic [IDX_W-1:0] idxy_c;
	logic signed [fvnh_pkg::LAT_W-1:0] lat_w [4][4];
	logic signed [SMW-1:0] sm_c [4];
	logic signed [SMW-1:0] nz_c;

	function automatic logic [31:0] trunc_int(input logic signed [31:0] v);
		logic [31:0] fl;
		fl = v >>> 16;
		return (v[31] && (v[15:0] != '0)) ? fl + 32'd1 : fl;
	endfunction

	function automatic logic [IDX_W-1:0] fade_idx(input logic signed [31:0] v);
		logic [15:0] mag;
		logic [31:0] prod;
		mag = v[31] ? 16'(17'd65536 - {1'b0, v[15:0]}) : v[15:0];
		prod = 32'(mag) * 32'(FADE_TABLE_DEPTH);
		return IDX_W'(prod >> 16);
	endfunction

	assign ix_c = trunc_int(sx_s1);
	assign iy_c = trunc_int(sy_s1);
	assign idxx_c = fade_idx(sx_s1);
	assign idxy_c = fade_idx(sy_s1);

	for (genvar j = 0; j < 4; j++) begin : g_row
		for (genvar i = 0; i < 4; i++) begin : g_col
			fvnh_hash u_hash (
				.clk (clk),
				.x   (ix_s2 + 32'(i) - 32'd1),
				.y   (iy_s2 + 32'(j) - 32'd1),
				.lat (lat_w[j][i])
			);
		end
	end

	always_comb begin
		logic signed [SMW-1:0] c;
		logic signed [SMW-1:0] s;
		logic signed [SMW-1:0] m;
		for (int k = 0; k < 4; k++) begin
			c = SMW'(lat_w[k/2][k%2]) + SMW'(lat_w[k/2][k%2+2])
				+ SMW'(lat_w[k/2+2][k%2]) + SMW'(lat_w[k/2+2][k%2+2]);
			s = SMW'(lat_w[k/2+1][k%2]) + SMW'(lat_w[k/2+1][k%2+2])
				+ SMW'(lat_w[k/2][k%2+1]) + SMW'(lat_w[k/2+2][k%2+1]);
			m = SMW'(lat_w[k/2+1][k%2+1]);
			sm_c[k] = (c >>> 4) + (s >>> 3) + (m >>> 2);
		end
	end

	assign nz_c = blend(bx0_s8, bx1_s8, ctl_s8.fy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= qx.v;
		sy_s1 <= qy.v;
		sat_s1 <= qx.sat | qy.sat;
		sat_s2 <= sat_s1;
		ix_s2 <= ix_c;
		iy_s2 <= iy_c;
		idxx_s2 <= idxx_c;
		idxy_s2 <= idxy_c;
		ctl_s3.sat <= sat_s2;
		ctl_s3.fx <= fade_rom[idxx_s2];
		ctl_s3.fy <= fade_rom[idxy_s2];
		ctl_s4 <= ctl_s3;
		ctl_s5 <= ctl_s4;
		ctl_s6 <= ctl_s5;
		ctl_s7 <= ctl_s6;
		ctl_s8 <= ctl_s7;
		sm_s7 <= sm_c;
		bx0_s8 <= blend(sm_s7[0], sm_s7[1], ctl_s7.fx);
		bx1_s8 <= blend(sm_s7[2], sm_s7[3], ctl_s7.fx);
		rnd_s9.sat <= ctl_s8.sat;
		rnd_s9.nz <= 32'(nz_c);
		rnd_s9.amp <= start_amplitude_q;
		rnd_s9.ret <= fvnh_pkg::ONE_Q16;
	end

	logic chain_vld [NR+1];
	fvnh_pkg::rnd_t chain_d [NR+1];

	assign chain_vld[0] = vld_s9;
	assign chain_d[0] = rnd_s9;

	for (genvar r = 0; r < NR; r++) begin : g_round
		fvnh_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      ({1'b0, octave_count_q} > 6'(r + 1)),
			.gain_h  (gain_h_q),
			.offset  (offset_q),
			.in_vld  (chain_vld[r]),
			.in_d    (chain_d[r]),
			.out_vld (chain_vld[r+1]),
			.out_d   (chain_d[r+1])
		);
	end

	logic done_q;
	logic signed [31:0] height_q;
	logic saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_vld[NR];
		end
	end

	always_ff @(posedge clk) begin
		height_q <= chain_d[NR].ret;
		saturated_q <= chain_d[NR].sat;
	end

	assign done = done_q;
	assign height = height_q;
	assign saturated = saturated_q;

endmodule

// ----- hw/rtl/fvnh_hash.sv -----
module fvnh_hash (
	input  logic                               clk,
	input  logic [31:0]                        x,
	input  logic [31:0]                        y,
	output logic signed [fvnh_pkg::LAT_W-1:0]  lat
);

	logic [31:0] n0;
	logic [31:0] n_s1;
	logic [31:0] n_s2;
	logic [31:0] nn_s2;
	logic [31:0] n_s3;
	logic [31:0] p_s3;
	logic [31:0] t;
	logic signed [fvnh_pkg::LAT_W-1:0] lat_s4;

	assign n0 = x + 32'(y * 32'd57);
	assign t = 32'(n_s3 * p_s3) + 32'd1376312589;

	always_ff @(posedge clk) begin
		n_s1 <= (n0 << 13) ^ n0;
		n_s2 <= n_s1;
		nn_s2 <= 32'(n_s1 * n_s1);
		n_s3 <= n_s2;
		p_s3 <= 32'(nn_s2 * 32'd15731) + 32'd789221;
		lat_s4 <= 18'sd65536 - signed'({1'b0, t[30:14]});
	end

	assign lat = lat_s4;

endmodule

// ----- hw/rtl/fvnh_round.sv -----
module fvnh_round (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [31:0] gain_h,
	input  logic signed [31:0] offset,
	input  logic               in_vld,
	input  fvnh_pkg::rnd_t     in_d,
	output logic               out_vld,
	output fvnh_pkg::rnd_t     out_d
);

	fvnh_pkg::qmul_t t1;
	fvnh_pkg::qmul_t an;
	fvnh_pkg::qmul_t t2;
	fvnh_pkg::qmul_t rn;
	fvnh_pkg::rnd_t d_s1;
	fvnh_pkg::rnd_t d_s2;
	fvnh_pkg::rnd_t d_s3;
	fvnh_pkg::rnd_t d1_c;
	fvnh_pkg::rnd_t d2_c;
	fvnh_pkg::rnd_t d3_c;
	logic signed [31:0] t1_s1;
	logic signed [31:0] t2_s2;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;

	assign t1 = fvnh_pkg::qmul(in_d.nz, in_d.amp);
	assign an = fvnh_pkg::qmul(in_d.amp, gain_h);
	assign t2 = fvnh_pkg::qmul(offset, t1_s1);
	assign rn = fvnh_pkg::qmul(d_s2.ret, t2_s2);

	always_comb begin
		d1_c = in_d;
		d1_c.amp = en ? an.v : in_d.amp;
		d1_c.sat = in_d.sat | (en & (t1.sat | an.sat));
		d2_c = d_s1;
		d2_c.sat = d_s1.sat | (en & t2.sat);
		d3_c = d_s2;
		d3_c.ret = en ? rn.v : d_s2.ret;
		d3_c.sat = d_s2.sat | (en & rn.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d1_c;
		t1_s1 <= t1.v;
		d_s2 <= d2_c;
		t2_s2 <= t2.v;
		d_s3 <= d3_c;
	end

	assign out_vld = vld_s3;
	assign out_d = d_s3;

endmodule

// ----- hw/rtl/fvnh_check.sv -----
module fvnh_check #(
	parameter int MAX_OCTAVES = fvnh_pkg::MAX_OCTAVES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int LAT = 3 * MAX_OCTAVES + 7;
	localparam int AGE_W = $clog2(LAT + 2);

	logic [AGE_W-1:0] age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(LAT + 1)) begin
			age_q <= age_q + AGE_W'(1);
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done high during reset");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(age_q == AGE_W'(LAT + 1)) |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match transfer latency");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(age_q < AGE_W'(LAT)) |-> !done)
		else $error("result before any transfer could finish");

endmodule

bind fractal_value_noise_height_top fvnh_check #(.MAX_OCTAVES(MAX_OCTAVES)) u_fvnh_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
